@@ src/jdg_pkg.sv @@
// Shared types, constants and lookup tables of the Julian Day converter.
`timescale 1ns / 1ps
`default_nettype none

package jdg_pkg;

    // Field widths of the external item formats.
    localparam int DN_W     = 23;
    localparam int YEAR_W   = 15;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int FRAC_W   = 32;
    localparam int WDAY_W   = 3;
    localparam int YDAY_W   = 9;

    // Internal widths.
    localparam int B_W      = 24;   // Meeus B term of the inverse conversion
    localparam int YFULL_W  = 17;   // year before wrapping to the output width
    localparam int DAYF_W   = 10;   // day of month before wrapping
    localparam int CENT_W   = 15;   // Meeus C term (Julian years since -4716)
    localparam int Q100_W   = 8;    // quotient of a year magnitude by 100
    localparam int ALPHA_W  = 8;    // Gregorian correction count

    // Packed stream widths.
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 96;

    // First day number of the Gregorian calendar (1582 October 15).
    localparam logic [DN_W-1:0] GREG_START = 23'd2299161;

    // Integer forms of the book's real constants.
    localparam int ALPHA_OFS   = 7468865;   // 4 * 1867216.25
    localparam int DAY_OFS     = 1524;
    localparam int CENT_OFS    = 12210;     // 100 * 122.1
    localparam int YEAR_OFS    = 4716;
    localparam int YEAR_OFS_JF = 4715;      // January and February
    localparam int QUAD_DAYS   = 1461;      // 4 * 365.25

    // Reciprocal constants: floor(x / D) = (x * R) >> K, exact for the
    // operand widths used here because x * (R * D - 2^K) < 2^K.
    localparam int K_DIV100    = 24;
    localparam int R_DIV100_W  = 18;
    localparam logic [R_DIV100_W-1:0] R_DIV100 =
        R_DIV100_W'(((64'd1 << K_DIV100) + 64'd99) / 64'd100);

    localparam int K_ALPHA     = 43;
    localparam int R_ALPHA_W   = 26;
    localparam logic [R_ALPHA_W-1:0] R_ALPHA =
        R_ALPHA_W'(((64'd1 << K_ALPHA) + 64'd146096) / 64'd146097);

    localparam int K_CENT      = 46;
    localparam int R_CENT_W    = 31;
    localparam logic [R_CENT_W-1:0] R_CENT =
        R_CENT_W'(((64'd1 << K_CENT) + 64'd36524) / 64'd36525);

    // floor(x * 10000 / 306001) for x below 1024.
    localparam int K_MON       = 29;
    localparam int R_MON_W     = 25;
    localparam logic [R_MON_W-1:0] R_MON =
        R_MON_W'(((64'd10000 << K_MON) + 64'd306000) / 64'd306001);

    localparam int K_DIV7      = 27;
    localparam int R_DIV7_W    = 25;
    localparam logic [R_DIV7_W-1:0] R_DIV7 =
        R_DIV7_W'(((64'd1 << K_DIV7) + 64'd6) / 64'd7);

    // Input item as taken from the stream.
    typedef struct packed {
        logic                      action;
        logic signed [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0]        month;
        logic [DAY_W-1:0]          day;
        logic [FRAC_W-1:0]         frac;
        logic [DN_W-1:0]           day_number;
    } jdg_in_t;

    // Hand-over from the front stages: the day number is final for the
    // forward direction, B is ready for the inverse direction.
    typedef struct packed {
        logic                      action;
        logic signed [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0]        month;
        logic [DAY_W-1:0]          day;
        logic [FRAC_W-1:0]         frac;
        logic [DN_W-1:0]           day_number;
        logic [B_W-1:0]            b;
    } jdg_mid_t;

    // Calendar date of either direction, before the leap and ordinal step.
    typedef struct packed {
        logic [DN_W-1:0]           day_number;
        logic signed [YFULL_W-1:0] year;
        logic [MONTH_W-1:0]        month;
        logic [DAYF_W-1:0]         day;
        logic [FRAC_W-1:0]         frac;
        logic [WDAY_W-1:0]         weekday;
    } jdg_date_t;

    // Result item.
    typedef struct packed {
        logic [DN_W-1:0]           day_number;
        logic [YEAR_W-1:0]         year;
        logic [MONTH_W-1:0]        month;
        logic [DAY_W-1:0]          day;
        logic [FRAC_W-1:0]         frac;
        logic [WDAY_W-1:0]         weekday;
        logic [YDAY_W-1:0]         year_day;
        logic                      leap;
    } jdg_out_t;

    // floor(30.6001 * x): days before a month in the March-based year.
    // The forward path reaches x = 16 when a month field of 15 is given.
    function automatic logic [8:0] mon_days(input logic [4:0] x);
        logic [8:0] r;
        begin
            case (x)
                5'd0:    r = 9'd0;
                5'd1:    r = 9'd30;
                5'd2:    r = 9'd61;
                5'd3:    r = 9'd91;
                5'd4:    r = 9'd122;
                5'd5:    r = 9'd153;
                5'd6:    r = 9'd183;
                5'd7:    r = 9'd214;
                5'd8:    r = 9'd244;
                5'd9:    r = 9'd275;
                5'd10:   r = 9'd306;
                5'd11:   r = 9'd336;
                5'd12:   r = 9'd367;
                5'd13:   r = 9'd397;
                5'd14:   r = 9'd428;
                5'd15:   r = 9'd459;
                5'd16:   r = 9'd489;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // floor(275 * x / 9): cumulative month lengths for the ordinal day.
    function automatic logic [8:0] ord_days(input logic [3:0] x);
        logic [8:0] r;
        begin
            case (x)
                4'd0:    r = 9'd0;
                4'd1:    r = 9'd30;
                4'd2:    r = 9'd61;
                4'd3:    r = 9'd91;
                4'd4:    r = 9'd122;
                4'd5:    r = 9'd152;
                4'd6:    r = 9'd183;
                4'd7:    r = 9'd213;
                4'd8:    r = 9'd244;
                4'd9:    r = 9'd275;
                4'd10:   r = 9'd305;
                4'd11:   r = 9'd336;
                4'd12:   r = 9'd366;
                4'd13:   r = 9'd397;
                4'd14:   r = 9'd427;
                4'd15:   r = 9'd458;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

@@ src/jdg_split.sv @@
// Front stages: date to day number, and the first steps of the inverse path.
`timescale 1ns / 1ps
`default_nettype none

module jdg_split
    import jdg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire jdg_in_t  in_item,
    output logic          out_valid,
    input  wire logic     out_ready,
    output jdg_mid_t      out_item
);

    typedef struct packed {
        logic                     action;
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic [FRAC_W-1:0]        frac;
        logic [DN_W-1:0]          z;
        logic                     ge;
        logic [DN_W+1:0]          ax;
        logic [MONTH_W-1:0]       m_adj;
        logic                     ya_neg;
        logic [14:0]              ya_mag;
        logic signed [15:0]       yoff;
    } s1_t;

    typedef struct packed {
        logic                     action;
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic [FRAC_W-1:0]        frac;
        logic [DN_W-1:0]          z;
        logic                     ge;
        logic [ALPHA_W-1:0]       alpha;
        logic [MONTH_W-1:0]       m_adj;
        logic                     ya_neg;
        logic [Q100_W-1:0]        q_a;
        logic signed [27:0]       p1461;
    } s2_t;

    logic     v1_reg, v2_reg, v3_reg;
    logic     v1_next, v2_next, v3_next;
    logic     en1, en2, en3;
    s1_t      s1_reg, s1_next;
    s2_t      s2_reg, s2_next;
    jdg_mid_t s3_reg, s3_next;

    // Stage 1 locals.
    logic signed [15:0] y_ext;
    logic signed [15:0] y_adj;
    logic               le2;

    // Stage 2 locals.
    logic [32:0] q100_prod;
    logic [50:0] alpha_prod;

    // Stage 3 locals.
    logic [Q100_W-1:0]  t_cent;
    logic [DN_W-1:0]    b_gc;
    logic signed [27:0] q1461;
    logic [DN_W-1:0]    dn_fwd;
    logic [B_W-1:0]     b_term;

    // A stage loads when it is empty or its successor moves on.
    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        v1_next = en1 ? in_valid : v1_reg;
        v2_next = en2 ? v1_reg : v2_reg;
        v3_next = en3 ? v2_reg : v3_reg;
    end

    // Stage 1: shift January and February to the previous year, prepare
    // the operands of both directions.
    always_comb
    begin
        y_ext          = {in_item.year[YEAR_W-1], in_item.year};
        le2            = (in_item.month <= 4'd2);
        y_adj          = le2 ? (y_ext - 16'sd1) : y_ext;
        s1_next.action = in_item.action;
        s1_next.year   = in_item.year;
        s1_next.month  = in_item.month;
        s1_next.day    = in_item.day;
        s1_next.frac   = in_item.frac;
        s1_next.z      = in_item.day_number;
        s1_next.ge     = (in_item.day_number >= GREG_START);
        s1_next.ax     = {in_item.day_number, 2'b00} - (DN_W+2)'(ALPHA_OFS);
        s1_next.m_adj  = le2 ? (in_item.month + 4'd12) : in_item.month;
        s1_next.ya_neg = y_adj[15];
        s1_next.ya_mag = 15'(y_adj[15] ? -y_adj : y_adj);
        s1_next.yoff   = y_adj + 16'(YEAR_OFS);
    end

    // Stage 2: the three multiplications.
    always_comb
    begin
        q100_prod      = 33'(s1_reg.ya_mag) * 33'(R_DIV100);
        alpha_prod     = 51'(s1_reg.ax) * 51'(R_ALPHA);
        s2_next.action = s1_reg.action;
        s2_next.year   = s1_reg.year;
        s2_next.month  = s1_reg.month;
        s2_next.day    = s1_reg.day;
        s2_next.frac   = s1_reg.frac;
        s2_next.z      = s1_reg.z;
        s2_next.ge     = s1_reg.ge;
        s2_next.alpha  = alpha_prod[K_ALPHA +: ALPHA_W];
        s2_next.m_adj  = s1_reg.m_adj;
        s2_next.ya_neg = s1_reg.ya_neg;
        s2_next.q_a    = q100_prod[K_DIV100 +: Q100_W];
        s2_next.p1461  = s1_reg.yoff * 28'sd1461;
    end

    // Stage 3: the forward day number (kept modulo 2^23) and B of the
    // inverse direction. Quotients truncate toward zero.
    always_comb
    begin
        t_cent  = s2_reg.q_a - {2'b00, s2_reg.q_a[Q100_W-1:2]};
        b_gc    = s2_reg.ya_neg ? (23'd2 + 23'(t_cent)) : (23'd2 - 23'(t_cent));
        q1461   = s2_reg.p1461[27] ? ((s2_reg.p1461 + 28'sd3) >>> 2)
                                   : (s2_reg.p1461 >>> 2);
        dn_fwd  = 23'(q1461) + 23'(mon_days({1'b0, s2_reg.m_adj} + 5'd1))
                  + 23'(s2_reg.day) + b_gc - 23'(DAY_OFS);
        b_term  = s2_reg.ge ? (24'(DAY_OFS + 1) + 24'(s2_reg.alpha)
                               - 24'(s2_reg.alpha[ALPHA_W-1:2]))
                            : 24'(DAY_OFS);
        s3_next.action     = s2_reg.action;
        s3_next.year       = s2_reg.year;
        s3_next.month      = s2_reg.month;
        s3_next.day        = s2_reg.day;
        s3_next.frac       = s2_reg.frac;
        s3_next.day_number = s2_reg.action ? s2_reg.z : dn_fwd;
        s3_next.b          = 24'(s2_reg.z) + b_term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
        if (en3)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = s3_reg;

`ifndef ASSERT_OFF
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !en1) |=> (v1_reg && $stable(s1_reg)))
        else $error("stage 1 changed while stalled");
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !en2) |=> (v2_reg && $stable(s2_reg)))
        else $error("stage 2 changed while stalled");
`endif

endmodule

`default_nettype wire

@@ src/jdg_civil.sv @@
// Middle stages: day number to Julian or Gregorian date, and the weekday.
`timescale 1ns / 1ps
`default_nettype none

module jdg_civil
    import jdg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire jdg_mid_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output jdg_date_t      out_item
);

    typedef struct packed {
        logic                     action;
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic [FRAC_W-1:0]        frac;
        logic [DN_W-1:0]          dnu;
        logic [B_W-1:0]           b;
        logic [29:0]              x100;
        logic [DN_W:0]            w;
    } s4_t;

    typedef struct packed {
        logic                     action;
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic [FRAC_W-1:0]        frac;
        logic [DN_W-1:0]          dnu;
        logic [B_W-1:0]           b;
        logic [CENT_W-1:0]        c;
        logic [DN_W:0]            w;
        logic [20:0]              wq;
    } s5_t;

    typedef struct packed {
        logic                     action;
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic [FRAC_W-1:0]        frac;
        logic [DN_W-1:0]          dnu;
        logic [CENT_W-1:0]        c;
        logic [DAYF_W-1:0]        bd;
        logic [WDAY_W-1:0]        weekday;
    } s6_t;

    typedef struct packed {
        logic                     action;
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic [FRAC_W-1:0]        frac;
        logic [DN_W-1:0]          dnu;
        logic [CENT_W-1:0]        c;
        logic [DAYF_W-1:0]        bd;
        logic [3:0]               e;
        logic [WDAY_W-1:0]        weekday;
    } s7_t;

    logic      v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic      v4_next, v5_next, v6_next, v7_next, v8_next;
    logic      en4, en5, en6, en7, en8;
    s4_t       s4_reg, s4_next;
    s5_t       s5_reg, s5_next;
    s6_t       s6_reg, s6_next;
    s7_t       s7_reg, s7_next;
    jdg_date_t s8_reg, s8_next;

    logic [60:0]               c_prod;
    logic [48:0]               wq_prod;
    logic [25:0]               d_prod;
    logic [DN_W:0]             w_rem;
    logic [34:0]               e_prod;
    logic [DAYF_W-1:0]         day_inv;
    logic [MONTH_W-1:0]        month_inv;
    logic signed [YFULL_W-1:0] c_ext;
    logic signed [YFULL_W-1:0] year_inv;

    assign en8      = !v8_reg || out_ready;
    assign en7      = !v7_reg || en8;
    assign en6      = !v6_reg || en7;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign in_ready = en4;

    always_comb
    begin
        v4_next = en4 ? in_valid : v4_reg;
        v5_next = en5 ? v4_reg : v5_reg;
        v6_next = en6 ? v5_reg : v6_reg;
        v7_next = en7 ? v6_reg : v7_reg;
        v8_next = en8 ? v7_reg : v8_reg;
    end

    // Stage 4: 100 * B - 12210, and the weekday operand.
    always_comb
    begin
        s4_next.action = in_item.action;
        s4_next.year   = in_item.year;
        s4_next.month  = in_item.month;
        s4_next.day    = in_item.day;
        s4_next.frac   = in_item.frac;
        s4_next.dnu    = in_item.day_number;
        s4_next.b      = in_item.b;
        s4_next.x100   = 30'(in_item.b) * 30'd100 - 30'(CENT_OFS);
        s4_next.w      = {1'b0, in_item.day_number} + 24'd1;
    end

    // Stage 5: C = floor((100 B - 12210) / 36525) and floor(w / 7).
    always_comb
    begin
        c_prod        = 61'(s4_reg.x100) * 61'(R_CENT);
        wq_prod       = 49'(s4_reg.w) * 49'(R_DIV7);
        s5_next.action = s4_reg.action;
        s5_next.year   = s4_reg.year;
        s5_next.month  = s4_reg.month;
        s5_next.day    = s4_reg.day;
        s5_next.frac   = s4_reg.frac;
        s5_next.dnu    = s4_reg.dnu;
        s5_next.b      = s4_reg.b;
        s5_next.c      = c_prod[K_CENT +: CENT_W];
        s5_next.w      = s4_reg.w;
        s5_next.wq     = wq_prod[K_DIV7 +: 21];
    end

    // Stage 6: D = floor(1461 C / 4), the day count B - D into the
    // March-based year, and the weekday remainder.
    always_comb
    begin
        d_prod          = 26'(s5_reg.c) * 26'(QUAD_DAYS);
        w_rem           = s5_reg.w - (24'(s5_reg.wq) * 24'd7);
        s6_next.action  = s5_reg.action;
        s6_next.year    = s5_reg.year;
        s6_next.month   = s5_reg.month;
        s6_next.day     = s5_reg.day;
        s6_next.frac    = s5_reg.frac;
        s6_next.dnu     = s5_reg.dnu;
        s6_next.c       = s5_reg.c;
        s6_next.bd      = DAYF_W'(s5_reg.b - d_prod[25:2]);
        s6_next.weekday = w_rem[WDAY_W-1:0];
    end

    // Stage 7: E = floor((B - D) / 30.6001).
    always_comb
    begin
        e_prod          = 35'(s6_reg.bd) * 35'(R_MON);
        s7_next.action  = s6_reg.action;
        s7_next.year    = s6_reg.year;
        s7_next.month   = s6_reg.month;
        s7_next.day     = s6_reg.day;
        s7_next.frac    = s6_reg.frac;
        s7_next.dnu     = s6_reg.dnu;
        s7_next.c       = s6_reg.c;
        s7_next.bd      = s6_reg.bd;
        s7_next.e       = e_prod[K_MON +: 4];
        s7_next.weekday = s6_reg.weekday;
    end

    // Stage 8: day, month and year of the inverse direction; the forward
    // direction echoes its input date.
    always_comb
    begin
        day_inv   = s7_reg.bd - DAYF_W'(mon_days({1'b0, s7_reg.e}));
        month_inv = (s7_reg.e >= 4'd14) ? (s7_reg.e - 4'd13) : (s7_reg.e - 4'd1);
        c_ext     = $signed({2'b00, s7_reg.c});
        year_inv  = (month_inv <= 4'd2) ? (c_ext - 17'(YEAR_OFS_JF))
                                        : (c_ext - 17'(YEAR_OFS));
        s8_next.day_number = s7_reg.dnu;
        s8_next.year       = s7_reg.action ? year_inv
                             : {{(YFULL_W-YEAR_W){s7_reg.year[YEAR_W-1]}}, s7_reg.year};
        s8_next.month      = s7_reg.action ? month_inv : s7_reg.month;
        s8_next.day        = s7_reg.action ? day_inv : DAYF_W'(s7_reg.day);
        s8_next.frac       = s7_reg.frac;
        s8_next.weekday    = s7_reg.weekday;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v4_next;
            v5_reg <= v5_next;
            v6_reg <= v6_next;
            v7_reg <= v7_next;
            v8_reg <= v8_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_reg <= s4_next;
        end
        if (en5)
        begin
            s5_reg <= s5_next;
        end
        if (en6)
        begin
            s6_reg <= s6_next;
        end
        if (en7)
        begin
            s7_reg <= s7_next;
        end
        if (en8)
        begin
            s8_reg <= s8_next;
        end
    end

    assign out_valid = v8_reg;
    assign out_item  = s8_reg;

`ifndef ASSERT_OFF
    a_e_range: assert property (@(posedge clk) disable iff (!rst_n)
        (v7_reg && s7_reg.action) |-> (s7_reg.e >= 4'd4))
        else $error("month index of an inverse conversion below four");
    a_wday_range: assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg |-> (s6_reg.weekday <= 3'd6))
        else $error("weekday remainder out of range");
`endif

endmodule

`default_nettype wire

@@ src/jdg_calendar.sv @@
// Final stages: leap-year flag, day of the year and the output register.
`timescale 1ns / 1ps
`default_nettype none

module jdg_calendar
    import jdg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire jdg_date_t  in_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output jdg_out_t        out_item
);

    typedef struct packed {
        logic [DN_W-1:0]    day_number;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [FRAC_W-1:0]  frac;
        logic [WDAY_W-1:0]  weekday;
        logic [15:0]        ymag;
        logic [Q100_W-1:0]  q;
        logic [YDAY_W-1:0]  yd_base;
        logic [1:0]         mgt;
    } s9_t;

    logic     v9_reg, v10_reg;
    logic     v9_next, v10_next;
    logic     en9, en10;
    s9_t      s9_reg, s9_next;
    jdg_out_t s10_reg, s10_next;

    logic [15:0]       ymag;
    logic [33:0]       q_prod;
    logic [15:0]       rem100;
    logic              lp;
    logic [YDAY_W-1:0] yd_sub;

    assign en10     = !v10_reg || out_ready;
    assign en9      = !v9_reg || en10;
    assign in_ready = en9;

    always_comb
    begin
        v9_next  = en9 ? in_valid : v9_reg;
        v10_next = en10 ? v9_reg : v10_reg;
    end

    // Stage 9: |year| / 100 and the month part of the ordinal day.
    always_comb
    begin
        ymag   = 16'(in_item.year[YFULL_W-1] ? -in_item.year : in_item.year);
        q_prod = 34'(ymag) * 34'(R_DIV100);
        s9_next.day_number = in_item.day_number;
        s9_next.year       = YEAR_W'(in_item.year);
        s9_next.month      = in_item.month;
        s9_next.day        = DAY_W'(in_item.day);
        s9_next.frac       = in_item.frac;
        s9_next.weekday    = in_item.weekday;
        s9_next.ymag       = ymag;
        s9_next.q          = q_prod[K_DIV100 +: Q100_W];
        s9_next.yd_base    = ord_days(in_item.month) + YDAY_W'(in_item.day) - 9'd30;
        // floor((month + 9) / 12) for the months the four bits can hold.
        if (in_item.month <= 4'd2)
        begin
            s9_next.mgt = 2'd0;
        end
        else if (in_item.month == 4'd15)
        begin
            s9_next.mgt = 2'd2;
        end
        else
        begin
            s9_next.mgt = 2'd1;
        end
    end

    // Stage 10: Gregorian leap rule on the full year, then the ordinal day.
    always_comb
    begin
        rem100 = s9_reg.ymag - (16'(s9_reg.q) * 16'd100);
        lp     = (s9_reg.ymag[1:0] == 2'b00)
                 && ((rem100 != 16'd0) || (s9_reg.q[1:0] == 2'b00));
        yd_sub = lp ? YDAY_W'(s9_reg.mgt) : YDAY_W'({s9_reg.mgt, 1'b0});
        s10_next.day_number = s9_reg.day_number;
        s10_next.year       = s9_reg.year;
        s10_next.month      = s9_reg.month;
        s10_next.day        = s9_reg.day;
        s10_next.frac       = s9_reg.frac;
        s10_next.weekday    = s9_reg.weekday;
        s10_next.year_day   = s9_reg.yd_base - yd_sub;
        s10_next.leap       = lp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end
        else
        begin
            v9_reg  <= v9_next;
            v10_reg <= v10_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en9)
        begin
            s9_reg <= s9_next;
        end
        if (en10)
        begin
            s10_reg <= s10_next;
        end
    end

    assign out_valid = v10_reg;
    assign out_item  = s10_reg;

`ifndef ASSERT_OFF
    a_leap_div4: assert property (@(posedge clk) disable iff (!rst_n)
        (v10_reg && s10_reg.leap) |-> (s10_reg.year[1:0] == 2'b00))
        else $error("leap flag set for a year not divisible by four");
`endif

endmodule

`default_nettype wire

@@ src/julian_day_gregorian_convert.sv @@
// Top level of the Julian Day and calendar date converter.
//
//  channel  direction  tdata (lowest bit first)                         tuser
//  s_axis   in         in_year 15s, in_month 4, in_day_whole 5,        action 1
//                      in_fraction 32, in_day_number 23, 1 zero bit
//  m_axis   out        out_day_number 23, out_year 15s, out_month 4,   none
//                      out_day_whole 5, out_fraction 32, weekday 3,
//                      year_day 9, leap 1, 4 zero bits
//
// One transaction is taken in every clock cycle while m_axis_tready is high; a
// result passes through every register stage before it can be taken. The depth
// of the pipeline is set by the chain of reciprocal multiplications of the
// inverse conversion, each followed by its own register.
// rst_n clears only the stage valid bits; payload registers are not reset.
// When m_axis_tready is low the stages stall from the output back, and an
// empty stage still takes data, so bubbles close up and nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module julian_day_gregorian_convert
    import jdg_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // in_year, in_month, in_day_whole, in_fraction, in_day_number, pad.
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action.
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // out_day_number, out_year, out_month, out_day_whole, out_fraction,
    // weekday, year_day, leap, pad.
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    jdg_in_t   in_item;
    jdg_mid_t  mid_item;
    jdg_date_t date_item;
    jdg_out_t  res_item;
    logic      mid_valid, mid_ready;
    logic      date_valid, date_ready;

    // Unpack the input transaction.
    assign in_item.action     = s_axis_tuser;
    assign in_item.year       = $signed(s_axis_tdata[14:0]);
    assign in_item.month      = s_axis_tdata[18:15];
    assign in_item.day        = s_axis_tdata[23:19];
    assign in_item.frac       = s_axis_tdata[55:24];
    assign in_item.day_number = s_axis_tdata[78:56];

    // Stages 1 to 3: forward day number, B of the inverse conversion.
    jdg_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_item  (mid_item)
    );

    // Stages 4 to 8: calendar date of a day number, and the weekday.
    jdg_civil u_civil (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_item   (mid_item),
        .out_valid (date_valid),
        .out_ready (date_ready),
        .out_item  (date_item)
    );

    // Stages 9 and 10: leap flag and ordinal day; stage 10 is the
    // output register.
    jdg_calendar u_calendar (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (date_valid),
        .in_ready  (date_ready),
        .in_item   (date_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (res_item)
    );

    // Pack the result transaction.
    assign m_axis_tdata = {4'b0000,
                           res_item.leap,
                           res_item.year_day,
                           res_item.weekday,
                           res_item.frac,
                           res_item.day,
                           res_item.month,
                           res_item.year,
                           res_item.day_number};

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking stream testbench for the Julian Day and calendar date converter.
`timescale 1ns / 1ps

module tb_top;
    import jdg_pkg::*;

    typedef enum bit {
        ACT_TO_DAY_NUMBER = 1'b0,
        ACT_TO_DATE       = 1'b1
    } action_t;

    typedef struct {
        action_t             action;
        bit signed [14:0]    year;
        bit [3:0]            month;
        bit [4:0]            day;
        bit [31:0]           frac;
        bit [22:0]           day_number;
    } conv_request_t;

    typedef struct {
        bit [22:0]           day_number;
        bit [14:0]           year;
        bit [3:0]            month;
        bit [4:0]            day;
        bit [31:0]           frac;
        bit [2:0]            weekday;
        bit [8:0]            year_day;
        bit                  leap;
    } conv_result_t;

    // Keeps the predicted result of every accepted input transaction in order
    // and compares the results coming out of the converter against them.
    class conversion_scoreboard;
        conv_result_t expected_conversions[$];
        int           mismatches;
        int           day_number_count;
        int           date_count;

        function new();
            mismatches       = 0;
            day_number_count = 0;
            date_count       = 0;
        endfunction

        // Calendar arithmetic with exact integer ratios; quotients truncate
        // toward zero, also for negative years.
        function conv_result_t convert_calendar(conv_request_t rq);
            conv_result_t r;
            longint y, m, yr, mo, dy, a, b, c, d, e, alpha, dn, k, ord;
            bit lp;
            if (rq.action == ACT_TO_DAY_NUMBER) begin
                y  = rq.year;
                m  = rq.month;
                yr = y;
                mo = m;
                dy = rq.day;
                // January and February count as months 13 and 14 of the
                // previous year; month zero falls into this case too.
                if (m <= 2) begin
                    y = y - 1;
                    m = m + 12;
                end
                a  = y / 100;
                b  = 2 - a + a / 4;
                dn = (1461 * (y + 4716)) / 4 + (306001 * (m + 1)) / 10000
                     + dy + b - 1524;
            end
            else begin
                dn = rq.day_number;
                a  = dn;
                // The Gregorian correction applies from 1582 October 15 on.
                if (dn >= GREG_START) begin
                    alpha = (4 * dn - 7468865) / 146097;
                    a     = dn + 1 + alpha - alpha / 4;
                end
                b  = a + 1524;
                c  = (100 * b - 12210) / 36525;
                d  = (1461 * c) / 4;
                e  = (10000 * (b - d)) / 306001;
                dy = b - d - (306001 * e) / 10000;
                mo = (e >= 14) ? e - 13 : e - 1;
                yr = (mo <= 2) ? c - 4715 : c - 4716;
            end
            // Leap flag and ordinal day use the full year, before it wraps.
            lp  = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
            k   = lp ? 1 : 2;
            ord = (275 * mo) / 9 - k * ((mo + 9) / 12) + dy - 30;
            r.day_number = dn[22:0];
            r.year       = yr[14:0];
            r.month      = mo[3:0];
            r.day        = dy[4:0];
            r.frac       = rq.frac;
            r.weekday    = 3'((longint'(r.day_number) + 1) % 7);
            r.year_day   = ord[8:0];
            r.leap       = lp;
            return r;
        endfunction

        function void note_request(conv_request_t rq);
            expected_conversions.push_back(convert_calendar(rq));
            if (rq.action == ACT_TO_DAY_NUMBER)
                day_number_count++;
            else
                date_count++;
        endfunction

        function void check_result(bit [OUT_TDATA_W-1:0] tdata);
            conv_result_t want;
            conv_result_t got;
            got.day_number = tdata[22:0];
            got.year       = tdata[37:23];
            got.month      = tdata[41:38];
            got.day        = tdata[46:42];
            got.frac       = tdata[78:47];
            got.weekday    = tdata[81:79];
            got.year_day   = tdata[90:82];
            got.leap       = tdata[91];
            if (expected_conversions.size() == 0) begin
                $error("result transaction with no conversion pending");
                mismatches++;
                return;
            end
            want = expected_conversions.pop_front();
            if (got.day_number != want.day_number) begin
                $error("out_day_number: expected %0d, got %0d",
                       want.day_number, got.day_number);
                mismatches++;
            end
            if (got.year != want.year) begin
                $error("out_year: expected %0d, got %0d",
                       $signed(want.year), $signed(got.year));
                mismatches++;
            end
            if (got.month != want.month) begin
                $error("out_month: expected %0d, got %0d", want.month, got.month);
                mismatches++;
            end
            if (got.day != want.day) begin
                $error("out_day_whole: expected %0d, got %0d", want.day, got.day);
                mismatches++;
            end
            if (got.frac != want.frac) begin
                $error("out_fraction: expected 0x%08h, got 0x%08h", want.frac, got.frac);
                mismatches++;
            end
            if (got.weekday != want.weekday) begin
                $error("weekday: expected %0d, got %0d", want.weekday, got.weekday);
                mismatches++;
            end
            if (got.year_day != want.year_day) begin
                $error("year_day: expected %0d, got %0d", want.year_day, got.year_day);
                mismatches++;
            end
            if (got.leap != want.leap) begin
                $error("leap: expected %0d, got %0d", want.leap, got.leap);
                mismatches++;
            end
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 1500;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Idle modes of the two stream sides, switched in phases by the stimulus.
    bit tx_stall_on = 1'b1;
    bit rx_stall_on = 1'b1;

    conversion_scoreboard board = new();

    julian_day_gregorian_convert uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    function automatic conv_request_t make_request(action_t act, int year, int month,
                                                   int day, bit [31:0] frac, int dn);
        conv_request_t rq;
        rq.action     = act;
        rq.year       = 15'(year);
        rq.month      = 4'(month);
        rq.day        = 5'(day);
        rq.frac       = frac;
        rq.day_number = 23'(dn);
        return rq;
    endfunction

    // Mostly plausible dates and day numbers; about one item in ten uses the
    // full width of every field. The unused fields always carry noise.
    function automatic conv_request_t make_random_request();
        conv_request_t rq;
        rq.action     = action_t'($urandom_range(0, 1));
        rq.year       = 15'($urandom);
        rq.month      = 4'($urandom);
        rq.day        = 5'($urandom);
        rq.frac       = $urandom;
        rq.day_number = 23'($urandom);
        if ($urandom_range(0, 9) != 0) begin
            rq.year       = 15'(int'($urandom_range(0, 14711)) - 4712);
            rq.month      = 4'($urandom_range(1, 12));
            rq.day        = 5'($urandom_range(1, 31));
            rq.day_number = 23'($urandom_range(0, 5373484));
        end
        return rq;
    endfunction

    // Presents one input transaction at a falling edge after a random gap and
    // holds it until the converter takes it at a rising edge.
    task automatic send_request(conv_request_t rq);
        int gap;
        gap = tx_stall_on ? $urandom_range(0, 12) : 0;
        @(negedge clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.action;
        s_axis_tdata  <= {1'b0, rq.day_number, rq.frac, rq.day, rq.month, rq.year};
        do @(posedge clk); while (!s_axis_tready);
        board.note_request(rq);
    endtask

    // Withdraws the last input transaction, then waits for every result.
    task automatic wait_for_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (board.expected_conversions.size() != 0)
            @(negedge clk);
    endtask

    // Result side: while rx_stall_on is set, stalls a random number of cycles before each transaction.
    initial begin
        int gap;
        wait (rst_n);
        forever begin
            gap = rx_stall_on ? $urandom_range(0, 12) : 0;
            @(negedge clk);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            board.check_result(m_axis_tdata);
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: field extremes, both directions, the calendar switch,
        // leap-year corner cases and out-of-range date fields.
        send_request(make_request(ACT_TO_DAY_NUMBER, 2000, 1, 1, 32'h0, 0));
        send_request(make_request(ACT_TO_DAY_NUMBER, -4712, 1, 1, 32'h8000_0000, 0));
        send_request(make_request(ACT_TO_DAY_NUMBER, 9999, 12, 31, 32'hFFFF_FFFF, 0));
        send_request(make_request(ACT_TO_DAY_NUMBER, 1582, 10, 15, 32'h1234_5678, 0));
        send_request(make_request(ACT_TO_DAY_NUMBER, 1582, 10, 4, 32'h0, 0));
        send_request(make_request(ACT_TO_DAY_NUMBER, 2000, 2, 29, 32'h0, 0));
        send_request(make_request(ACT_TO_DAY_NUMBER, 1900, 3, 1, 32'h0, 0));
        send_request(make_request(ACT_TO_DAY_NUMBER, -100, 3, 1, 32'h0, 0));
        send_request(make_request(ACT_TO_DAY_NUMBER, -1, 2, 28, 32'h0, 0));
        send_request(make_request(ACT_TO_DAY_NUMBER, 2024, 0, 0, 32'h0, 0));
        send_request(make_request(ACT_TO_DAY_NUMBER, 2023, 15, 31, 32'h0, 8388607));
        send_request(make_request(ACT_TO_DAY_NUMBER, -16384, 1, 1, 32'h0, 0));
        send_request(make_request(ACT_TO_DAY_NUMBER, 16383, 12, 31, 32'h0, 0));
        send_request(make_request(ACT_TO_DATE, 0, 0, 0, 32'h0, 0));
        send_request(make_request(ACT_TO_DATE, 0, 0, 0, 32'hFFFF_FFFF, 2299160));
        send_request(make_request(ACT_TO_DATE, 0, 0, 0, 32'h0, 2299161));
        send_request(make_request(ACT_TO_DATE, 0, 0, 0, 32'h0, 2451545));
        send_request(make_request(ACT_TO_DATE, 0, 0, 0, 32'h0, 2451604));
        send_request(make_request(ACT_TO_DATE, 0, 0, 0, 32'h0, 5373484));
        send_request(make_request(ACT_TO_DATE, 0, 0, 0, 32'h0, 5373485));
        send_request(make_request(ACT_TO_DATE, -1, 15, 31, 32'h0, 8388607));

        // The sender holds off until every pending conversion has come back.
        wait_for_drain();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // Cycle through idle modes so that every combination of stalls,
            // including none at all, gets a stretch of its own.
            if (i % 100 == 0) begin
                tx_stall_on = ((i / 100) % 4) inside {0, 1};
                rx_stall_on = ((i / 100) % 4) inside {0, 2};
            end
            if (i == RANDOM_ITEMS / 2)
                wait_for_drain();
            send_request(make_random_request());
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        wait_for_drain();
        repeat (30) @(posedge clk);

        $display("Checked %0d date-to-day-number and %0d day-number-to-date conversions,",
                 board.day_number_count, board.date_count);
        $display("with random idle cycles and stalls on both stream sides.");
        if (board.mismatches == 0 && board.expected_conversions.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run with full stalls.
    initial begin
        #4000000;
        $display("tb_top failed");
        $finish;
    end

endmodule

@@ julian_day_gregorian_convert.f @@
src/jdg_pkg.sv
src/jdg_split.sv
src/jdg_civil.sv
src/jdg_calendar.sv
src/julian_day_gregorian_convert.sv
sim/tb_top.sv
